[design/assert_macros.svh]
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/rmr_pkg.sv]
// shared constants and tables of the radar measurement residual block
package rmr_pkg;

    // register indexes
    localparam logic REG_SMALL_THRESHOLD = 1'b0;

    // angle constants
    localparam logic signed [27:0] PI_Q24     = 28'sd52707179;
    localparam logic signed [20:0] PI_Q16     = 21'sd205887;
    localparam logic signed [20:0] TWO_PI_Q16 = 21'sd411775;
    localparam logic signed [18:0] BEAR_MAX   = 19'sd205887;
    localparam logic signed [18:0] BEAR_MIN   = -19'sd205887;

    // pipeline geometry
    localparam int CORDIC_STEPS = 25;
    localparam int STAGES       = 71;

    // arctangent of 2^-i at scale 2^24
    function automatic logic signed [27:0] atan_q24(input logic [4:0] i);
        logic signed [27:0] a;
        unique case (i)
            5'd0:    a = 28'sd13176795;
            5'd1:    a = 28'sd7778716;
            5'd2:    a = 28'sd4110060;
            5'd3:    a = 28'sd2086331;
            5'd4:    a = 28'sd1047214;
            5'd5:    a = 28'sd524117;
            5'd6:    a = 28'sd262123;
            5'd7:    a = 28'sd131069;
            5'd8:    a = 28'sd65536;
            5'd9:    a = 28'sd32768;
            5'd10:   a = 28'sd16384;
            5'd11:   a = 28'sd8192;
            5'd12:   a = 28'sd4096;
            5'd13:   a = 28'sd2048;
            5'd14:   a = 28'sd1024;
            5'd15:   a = 28'sd512;
            5'd16:   a = 28'sd256;
            5'd17:   a = 28'sd128;
            5'd18:   a = 28'sd64;
            5'd19:   a = 28'sd32;
            5'd20:   a = 28'sd16;
            5'd21:   a = 28'sd8;
            5'd22:   a = 28'sd4;
            5'd23:   a = 28'sd2;
            5'd24:   a = 28'sd1;
            default: a = 28'sd0;
        endcase
        return a;
    endfunction

endpackage

[design/radar_measurement_residual.sv]
// radar measurement residual: polar conversion of a predicted state and residuals
// The block takes one item per clock cycle unless stalled and offers the results
// in acceptance order. The item passes 71 register stages: the
// capture stage, the multiply stage, the add stage, a 32-stage square root that
// resolves one root bit per stage, a divider setup stage, a 34-stage divider that
// resolves one quotient bit per stage, and the output register; the 25-step
// arctangent runs beside the square root. One stall signal freezes the whole
// pipeline when the output register is full and not taken. small_threshold is
// written over the APB port at byte address 0 and should be changed only while
// the pipeline is empty.
module radar_measurement_residual (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic [30:0]        meas_range,
    input  logic signed [18:0] meas_bearing,
    input  logic signed [31:0] meas_range_rate,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] range_residual,
    output logic signed [18:0] bearing_residual,
    output logic signed [31:0] range_rate_residual,
    output logic               bearing_defaulted,
    output logic               rate_defaulted
);

    localparam int LAST = rmr_pkg::STAGES - 1;

    // values that ride along the pipeline with each item
    typedef struct packed {
        logic [30:0]        mr;
        logic signed [18:0] mb;
        logic signed [31:0] mrate;
        logic               bdef;
        logic [63:0]        sm;
        logic               neg;
        logic signed [18:0] bear;
        logic [31:0]        rng;
        logic               rdef;
        logic               ovf;
    } side_t;

    logic [15:0] thr_reg;
    logic        adv;
    logic        vld_reg [0:LAST];

    side_t side_reg  [0:LAST-1];
    side_t side_next [0:LAST-1];

    logic signed [31:0] in_x_reg, in_y_reg, in_vx_reg, in_vy_reg;
    logic [63:0]        ax2_reg, ay2_reg, ax2_next, ay2_next;
    logic signed [63:0] pxv_reg, pyv_reg, pxv_next, pyv_next;
    logic               bdef_k1;

    logic [63:0] sqr_rem_reg   [2:34];
    logic [63:0] sqr_rem_next  [2:34];
    logic [31:0] sqr_root_reg  [2:34];
    logic [31:0] sqr_root_next [2:34];

    logic signed [55:0] cx_reg  [1:26];
    logic signed [55:0] cx_next [1:26];
    logic signed [55:0] cy_reg  [1:26];
    logic signed [55:0] cy_next [1:26];
    logic signed [27:0] cz_reg  [1:26];
    logic signed [27:0] cz_next [1:26];
    logic signed [18:0] bear_k27;

    logic [31:0] dv_rem_reg  [35:69];
    logic [31:0] dv_rem_next [35:69];
    logic [33:0] dv_q_reg    [35:69];
    logic [33:0] dv_q_next   [35:69];

    logic signed [31:0] rr_reg, rr_next, rrr_reg, rrr_next;
    logic signed [18:0] br_reg, br_next;
    logic               bd_reg, rd_reg;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == rmr_pkg::REG_SMALL_THRESHOLD) ? {16'd0, thr_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 16'd0;
        end
        else if (psel && penable && pwrite && (paddr[2] == rmr_pkg::REG_SMALL_THRESHOLD))
        begin
            thr_reg <= pwdata[15:0];
        end
    end

    // global advance: the pipeline moves unless a finished item is held
    assign adv      = !vld_reg[LAST] || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LAST; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= LAST; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // stage 0: capture
    always_comb
    begin
        side_next[0]       = '0;
        side_next[0].mr    = meas_range;
        side_next[0].mb    = meas_bearing;
        side_next[0].mrate = meas_range_rate;
    end

    // stage 1: squares, dot products, threshold on x, arctangent setup
    always_comb
    begin
        logic [31:0]        ax;
        logic [31:0]        ay;
        logic signed [55:0] xs;
        logic signed [55:0] ys;
        ax = in_x_reg[31] ? (32'd0 - in_x_reg) : in_x_reg;
        ay = in_y_reg[31] ? (32'd0 - in_y_reg) : in_y_reg;
        ax2_next = {32'd0, ax} * {32'd0, ax};
        ay2_next = {32'd0, ay} * {32'd0, ay};
        pxv_next = 64'(in_x_reg) * 64'(in_vx_reg);
        pyv_next = 64'(in_y_reg) * 64'(in_vy_reg);
        bdef_k1  = ax <= {16'd0, thr_reg};
        xs = {{4{in_x_reg[31]}}, in_x_reg, 20'd0};
        ys = {{4{in_y_reg[31]}}, in_y_reg, 20'd0};
        if (in_x_reg[31])
        begin
            cx_next[1] = -xs;
            cy_next[1] = -ys;
            cz_next[1] = in_y_reg[31] ? -rmr_pkg::PI_Q24 : rmr_pkg::PI_Q24;
        end
        else
        begin
            cx_next[1] = xs;
            cy_next[1] = ys;
            cz_next[1] = 28'sd0;
        end
    end

    // stage 2: sum of squares and dot product magnitude
    always_comb
    begin
        logic [64:0] s65;
        logic [63:0] s;
        logic        neg;
        s65 = {pxv_reg[63], pxv_reg} + {pyv_reg[63], pyv_reg};
        s   = s65[63:0];
        neg = s[63] && (|s[62:0]);
        sqr_rem_next[2]  = ax2_reg + ay2_reg;
        sqr_root_next[2] = 32'd0;
        side_next[2]     = side_reg[1];
        side_next[2].neg = neg;
        side_next[2].sm  = neg ? (64'd0 - s) : s;
    end

    always_comb
    begin
        side_next[1]      = side_reg[0];
        side_next[1].bdef = bdef_k1;
    end

    genvar k;

    // square root: one root bit per stage, most significant first
    for (k = 3; k <= 34; k++)
    begin : g_sqrt
        localparam int B = 34 - k;
        logic [65:0] t;
        logic        ge;
        assign t  = ({34'd0, sqr_root_reg[k-1]} << (B + 1)) + (66'd1 << (2 * B));
        assign ge = {2'd0, sqr_rem_reg[k-1]} >= t;
        assign sqr_rem_next[k]  = ge ? (sqr_rem_reg[k-1] - t[63:0]) : sqr_rem_reg[k-1];
        assign sqr_root_next[k] = ge ? (sqr_root_reg[k-1] | (32'd1 << B))
                                     : sqr_root_reg[k-1];
    end

    // arctangent: one vectoring step per stage
    for (k = 2; k <= 26; k++)
    begin : g_cordic
        localparam int I = k - 2;
        logic signed [55:0] xs;
        logic signed [55:0] ys;
        logic signed [27:0] a;
        assign xs = cx_reg[k-1] >>> I;
        assign ys = cy_reg[k-1] >>> I;
        assign a  = rmr_pkg::atan_q24(5'(I));
        assign cx_next[k] = cy_reg[k-1][55] ? (cx_reg[k-1] - ys) : (cx_reg[k-1] + ys);
        assign cy_next[k] = cy_reg[k-1][55] ? (cy_reg[k-1] + xs) : (cy_reg[k-1] - xs);
        assign cz_next[k] = cy_reg[k-1][55] ? (cz_reg[k-1] - a) : (cz_reg[k-1] + a);
    end

    // stage 27: round the angle to signed Q2.16 and clamp, or zero it when the bearing is defaulted
    always_comb
    begin
        logic signed [27:0] zr;
        zr = (cz_reg[26] + 28'sd128) >>> 8;
        if (side_reg[26].bdef)
        begin
            bear_k27 = 19'sd0;
        end
        else if (zr > 28'(rmr_pkg::PI_Q16))
        begin
            bear_k27 = rmr_pkg::BEAR_MAX;
        end
        else if (zr < -28'(rmr_pkg::PI_Q16))
        begin
            bear_k27 = rmr_pkg::BEAR_MIN;
        end
        else
        begin
            bear_k27 = zr[18:0];
        end
    end

    // stage 35: range threshold and divider setup
    always_comb
    begin
        logic [31:0] rng;
        rng = sqr_root_reg[34];
        side_next[35]      = side_reg[34];
        side_next[35].rng  = rng;
        side_next[35].rdef = rng <= {16'd0, thr_reg};
        side_next[35].ovf  = {2'd0, side_reg[34].sm[63:34]} >= rng;
        dv_rem_next[35]    = {2'd0, side_reg[34].sm[63:34]};
        dv_q_next[35]      = 34'd0;
    end

    // side values pass through the remaining stages
    for (k = 3; k <= LAST - 1; k++)
    begin : g_side
        if (k == 27)
        begin : g_bear
            always_comb
            begin
                side_next[k]      = side_reg[k-1];
                side_next[k].bear = bear_k27;
            end
        end
        else if (k != 35)
        begin : g_pass
            assign side_next[k] = side_reg[k-1];
        end
    end

    // divider: one quotient bit per stage, most significant first
    for (k = 36; k <= 69; k++)
    begin : g_div
        localparam int J = 69 - k;
        logic [32:0] r2;
        logic        ge;
        assign r2 = {dv_rem_reg[k-1], side_reg[k-1].sm[J]};
        assign ge = r2 >= {1'b0, side_reg[k-1].rng};
        assign dv_rem_next[k] = ge ? 32'(r2 - {1'b0, side_reg[k-1].rng}) : r2[31:0];
        assign dv_q_next[k]   = ge ? (dv_q_reg[k-1] | (34'd1 << J)) : dv_q_reg[k-1];
    end

    // output stage: clamp the rate, subtract, saturate, wrap the bearing
    always_comb
    begin
        side_t              s;
        logic [33:0]        qc;
        logic signed [35:0] rate;
        logic signed [33:0] dr;
        logic signed [36:0] dq;
        logic signed [20:0] db;
        s  = side_reg[LAST-1];
        qc = (s.ovf || (dv_q_reg[69] > (34'd1 << 33))) ? (34'd1 << 33) : dv_q_reg[69];
        if (s.rdef)
        begin
            rate = 36'sd0;
        end
        else if (s.neg)
        begin
            rate = -$signed({2'd0, qc});
        end
        else
        begin
            rate = $signed({2'd0, qc});
        end

        dr = $signed({3'd0, s.mr}) - $signed({2'd0, s.rng});
        if (dr > 34'sd2147483647)
        begin
            rr_next = 32'sh7fffffff;
        end
        else if (dr < -34'sd2147483648)
        begin
            rr_next = 32'sh80000000;
        end
        else
        begin
            rr_next = dr[31:0];
        end

        dq = 37'(s.mrate) - 37'(rate);
        if (dq > 37'sd2147483647)
        begin
            rrr_next = 32'sh7fffffff;
        end
        else if (dq < -37'sd2147483648)
        begin
            rrr_next = 32'sh80000000;
        end
        else
        begin
            rrr_next = dq[31:0];
        end

        db = 21'(s.mb) - 21'(s.bear);
        if (db > rmr_pkg::PI_Q16)
        begin
            db = db - rmr_pkg::TWO_PI_Q16;
        end
        else if (db < -rmr_pkg::PI_Q16)
        begin
            db = db + rmr_pkg::TWO_PI_Q16;
        end
        br_next = db[18:0];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_x_reg  <= pos_x;
            in_y_reg  <= pos_y;
            in_vx_reg <= vel_x;
            in_vy_reg <= vel_y;
            ax2_reg   <= ax2_next;
            ay2_reg   <= ay2_next;
            pxv_reg   <= pxv_next;
            pyv_reg   <= pyv_next;
            for (int i = 0; i <= LAST - 1; i++)
            begin
                side_reg[i] <= side_next[i];
            end
            for (int i = 2; i <= 34; i++)
            begin
                sqr_rem_reg[i]  <= sqr_rem_next[i];
                sqr_root_reg[i] <= sqr_root_next[i];
            end
            for (int i = 1; i <= 26; i++)
            begin
                cx_reg[i] <= cx_next[i];
                cy_reg[i] <= cy_next[i];
                cz_reg[i] <= cz_next[i];
            end
            for (int i = 35; i <= 69; i++)
            begin
                dv_rem_reg[i] <= dv_rem_next[i];
                dv_q_reg[i]   <= dv_q_next[i];
            end
            rr_reg  <= rr_next;
            rrr_reg <= rrr_next;
            br_reg  <= br_next;
            bd_reg  <= side_reg[LAST-1].bdef;
            rd_reg  <= side_reg[LAST-1].rdef;
        end
    end

    assign out_valid           = vld_reg[LAST];
    assign range_residual      = rr_reg;
    assign bearing_residual    = br_reg;
    assign range_rate_residual = rrr_reg;
    assign bearing_defaulted   = bd_reg;
    assign rate_defaulted      = rd_reg;

endmodule

[design/rmr_checker.sv]
// port-level checks of the radar measurement residual block
`include "assert_macros.svh"

module rmr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] range_residual,
    input logic signed [18:0] bearing_residual,
    input logic signed [31:0] range_rate_residual
);

    // input side backs up only behind a held result
    `ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall,
        "input stalled without a held item")

    // wrapped bearing stays within plus or minus pi
    `ASSERT_SAME(a_bear_range, out_valid,
        (bearing_residual <= rmr_pkg::BEAR_MAX) && (bearing_residual >= rmr_pkg::BEAR_MIN),
        "bearing residual out of range")

    // a held item stays offered
    `ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid, "held item dropped")

    // a held item keeps its residuals
    `ASSERT_NEXT(a_hold_data, out_valid && out_stall,
        $stable(range_residual) && $stable(range_rate_residual) && $stable(bearing_residual),
        "held item changed")

endmodule

bind radar_measurement_residual rmr_checker u_rmr_checker (.*);

[bench/tb.sv]
// testbench of the radar measurement residual block with a scoreboard class
module tb;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [30:0]        m_range;
        logic signed [18:0] m_bear;
        logic signed [31:0] m_rate;
    } track_item_t;

    typedef struct {
        logic signed [31:0] range_res;
        logic signed [18:0] bear_res;
        logic signed [31:0] rate_res;
        logic               bear_def;
        logic               rate_def;
    } residual_t;

    // predicted residuals in acceptance order
    class residual_scoreboard;
        residual_t   expected_q[$];
        logic [15:0] threshold;
        int          mismatches;

        function new();
            threshold  = 16'd0;
            mismatches = 0;
        endfunction

        task report_mismatch(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        // integer square root, one result bit per pass
        function bit [63:0] int_sqrt(bit [63:0] v);
            bit [63:0] res;
            bit [63:0] b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v   = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            return res;
        endfunction

        // vectoring cordic arctangent, angle worked at scale 2^24 and returned at scale 2^16
        function longint bearing_of(longint x, longint y);
            longint angle_tab[25] = '{13176795, 7778716, 4110060, 2086331, 1047214,
                524117, 262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024,
                512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
            longint z;
            longint xs;
            longint ys;
            z = 0;
            x = x * 1048576;
            y = y * 1048576;
            if (x < 0)
            begin
                z = (y >= 0) ? longint'(rmr_pkg::PI_Q24) : -longint'(rmr_pkg::PI_Q24);
                x = -x;
                y = -y;
            end
            for (int i = 0; i < 25; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + angle_tab[i];
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - angle_tab[i];
                end
            end
            z = (z + 128) >>> 8;
            if (z > longint'(rmr_pkg::PI_Q16))
                z = rmr_pkg::PI_Q16;
            if (z < -longint'(rmr_pkg::PI_Q16))
                z = -longint'(rmr_pkg::PI_Q16);
            return z;
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        // work out the residuals of one accepted item
        function void note_item(track_item_t it);
            residual_t r;
            longint    x, y, vx, vy, ax, ay, bear, rate, d;
            bit [63:0] rng, s, sm, q;
            bit        neg;
            x  = it.px;
            y  = it.py;
            vx = it.vx;
            vy = it.vy;
            ax = (x < 0) ? -x : x;
            ay = (y < 0) ? -y : y;
            rng = int_sqrt(ax * ax + ay * ay);
            r.bear_def = ax <= threshold;
            r.rate_def = rng <= threshold;
            bear = 0;
            rate = 0;
            if (!r.bear_def)
                bear = bearing_of(x, y);
            if (!r.rate_def)
            begin
                s   = x * vx + y * vy;
                neg = s > (64'd1 << 63);
                sm  = neg ? -s : s;
                q   = sm / rng;
                if (q > (64'd1 << 33))
                    q = 64'd1 << 33;
                rate = neg ? -longint'(q) : longint'(q);
            end
            d = longint'(it.m_bear) - bear;
            while (d > longint'(rmr_pkg::PI_Q16))
                d = d - rmr_pkg::TWO_PI_Q16;
            while (d < -longint'(rmr_pkg::PI_Q16))
                d = d + rmr_pkg::TWO_PI_Q16;
            r.range_res = 32'(clip32(longint'(it.m_range) - longint'(rng)));
            r.bear_res  = 19'(d);
            r.rate_res  = 32'(clip32(longint'(it.m_rate) - rate));
            expected_q.push_back(r);
        endfunction

        // compare one delivered result with the oldest prediction
        task check_result(residual_t got);
            residual_t e;
            if (expected_q.size() == 0)
            begin
                report_mismatch("result with nothing expected");
                return;
            end
            e = expected_q.pop_front();
            if (got.range_res !== e.range_res)
                report_mismatch($sformatf("range_residual %0d exp %0d",
                    got.range_res, e.range_res));
            if (got.bear_res !== e.bear_res)
                report_mismatch($sformatf("bearing_residual %0d exp %0d",
                    got.bear_res, e.bear_res));
            if (got.rate_res !== e.rate_res)
                report_mismatch($sformatf("range_rate_residual %0d exp %0d",
                    got.rate_res, e.rate_res));
            if (got.bear_def !== e.bear_def)
                report_mismatch($sformatf("bearing_defaulted %0b exp %0b",
                    got.bear_def, e.bear_def));
            if (got.rate_def !== e.rate_def)
                report_mismatch($sformatf("rate_defaulted %0b exp %0b",
                    got.rate_def, e.rate_def));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]        meas_range;
    logic signed [18:0] meas_bearing;
    logic signed [31:0] meas_range_rate;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] range_residual;
    logic signed [18:0] bearing_residual;
    logic signed [31:0] range_rate_residual;
    logic               bearing_defaulted;
    logic               rate_defaulted;

    residual_scoreboard sb = new();
    bit                 no_idle;
    bit                 hold_req;

    radar_measurement_residual i_dut (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20000000;
        $display("[radar_measurement_residual] ERROR");
        $finish;
    end

    // gap length: mostly none or short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: check accepted results, then decide the stall
    initial
    begin
        int        hold_left;
        residual_t got;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.range_res = range_residual;
                got.bear_res  = bearing_residual;
                got.rate_res  = range_rate_residual;
                got.bear_def  = bearing_defaulted;
                got.rate_def  = rate_defaulted;
                sb.check_result(got);
            end
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = 300;
            end
            else if (hold_left == 0 && !no_idle && $urandom_range(0, 99) < 25)
                hold_left = gap_len();
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // register write over the apb port
    task write_threshold(logic [15:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {rmr_pkg::REG_SMALL_THRESHOLD, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.threshold = value;
    endtask

    // offer one item until it is taken
    task send_item(track_item_t it);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        pos_x           <= it.px;
        pos_y           <= it.py;
        vel_x           <= it.vx;
        vel_y           <= it.vy;
        meas_range      <= it.m_range;
        meas_bearing    <= it.m_bear;
        meas_range_rate <= it.m_rate;
        in_valid        <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_item(it);
    endtask

    // signed value of random size near zero, around the threshold, or full range
    function automatic logic signed [31:0] rand_coord(logic [15:0] thr);
        int r;
        logic signed [31:0] v;
        r = $urandom_range(0, 99);
        if (r < 45)
            v = $urandom;
        else if (r < 80)
            v = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        else
            v = $signed({16'd0, thr}) + $signed($urandom_range(0, 4)) - 2;
        if (r >= 80 && $urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    function automatic track_item_t rand_item(logic [15:0] thr);
        track_item_t it;
        it.px      = rand_coord(thr);
        it.py      = rand_coord(thr);
        it.vx      = rand_coord(thr);
        it.vy      = rand_coord(thr);
        it.m_range = 31'($urandom);
        if ($urandom_range(0, 9) == 0)
            it.m_bear = 19'($urandom);
        else
            it.m_bear = 19'($signed($urandom_range(0, 411774)) - 205887);
        it.m_rate  = $urandom;
        return it;
    endfunction

    function automatic track_item_t mk(int px, int py, int vx, int vy,
                                       int mr, int mb, int mt);
        track_item_t it;
        it.px = px;
        it.py = py;
        it.vx = vx;
        it.vy = vy;
        it.m_range = 31'(mr);
        it.m_bear  = 19'(mb);
        it.m_rate  = mt;
        return it;
    endfunction

    // boundary items around the current threshold
    task send_threshold_edges(logic [15:0] thr);
        int t;
        t = thr;
        send_item(mk(t, 0, 65536, 0, 0, 0, 0));
        send_item(mk(-t, 3, 1, 1, 100, 1000, 0));
        send_item(mk(t + 1, 0, -65536, 7, 65536, -1000, 5));
        send_item(mk(-t - 1, -2, 9, -9, 0, 205887, -5));
        send_item(mk(0, t, 1, 65536, 3, -205887, 0));
        send_item(mk(0, -t - 1, 1, -65536, 3, 0, 0));
    endtask

    task drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task run_phase(logic [15:0] thr, int n, bit long_hold);
        write_threshold(thr);
        send_threshold_edges(thr);
        if (long_hold)
        begin
            no_idle  = 1'b1;
            hold_req = 1'b1;
        end
        for (int i = 0; i < n; i++)
        begin
            if (long_hold && i == 400)
                no_idle = 1'b0;
            send_item(rand_item(thr));
        end
        drain();
    endtask

    // stimulus
    initial
    begin
        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        in_valid        <= 1'b0;
        pos_x           <= '0;
        pos_y           <= '0;
        vel_x           <= '0;
        vel_y           <= '0;
        meas_range      <= '0;
        meas_bearing    <= '0;
        meas_range_rate <= '0;
        no_idle  = 1'b0;
        hold_req = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // field extremes, quadrants, saturation, out of range bearing
        send_item(mk(0, 0, 0, 0, 0, 0, 0));
        send_item(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     0, 0, 32'h7fff_ffff));
        send_item(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h7fff_ffff, 205887, 32'h8000_0000));
        send_item(mk(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                     32'h7fff_ffff, -205887, 32'h8000_0000));
        send_item(mk(32'h7fff_ffff, 0, 32'h7fff_ffff, 0, 0, 0, 32'h8000_0000));
        send_item(mk(-65536, 0, 65536, 0, 65536, 205887, 0));
        send_item(mk(-65536, -1, 65536, 0, 65536, -205887, 0));
        send_item(mk(65536, 65536, -65536, 65536, 92682, 51472, 0));
        send_item(mk(-65536, 65536, 1, 1, 0, 262143, 0));
        send_item(mk(-65536, -65536, 1, 1, 0, -262144, 0));
        send_item(mk(1, 1, 1, 1, 0, 1, -1));
        send_item(mk(65536, -65536, 0, 0, 0, 32'h0003_ffff, 0));
        drain();

        run_phase(16'd0, 460, 1'b0);
        run_phase(16'hffff, 460, 1'b1);
        run_phase($urandom_range(1, 65534), 460, 1'b0);
        run_phase(16'd1000, 460, 1'b0);

        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("[radar_measurement_residual] OK");
        else
            $display("[radar_measurement_residual] ERROR");
        $finish;
    end
endmodule
